// File: rtl/sme_pkg.sv
// Shared types and constants for the stack machine execute unit.
package sme_pkg;

    typedef enum logic [3:0] {
        CMD_CLEAR = 4'd0,
        CMD_IN    = 4'd1,
        CMD_OUT   = 4'd2,
        CMD_PUT   = 4'd3,
        CMD_POP   = 4'd4,
        CMD_ADD   = 4'd5,
        CMD_MUL   = 4'd6,
        CMD_DIV   = 4'd7,
        CMD_JMP   = 4'd8,
        CMD_JE    = 4'd9,
        CMD_JAE   = 4'd10,
        CMD_GOSUB = 4'd11,
        CMD_RET   = 4'd12,
        CMD_END   = 4'd13
    } t_cmd;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_UNDER = 2'd1;
    localparam logic [1:0] ERR_OVER  = 2'd2;
    localparam logic [1:0] ERR_DIV0  = 2'd3;

    localparam logic [7:0] REG_CODE_FIRST = 8'd50;
    localparam logic [7:0] REG_CODE_LAST  = 8'd53;
    localparam logic [8:0] CALL_RETURN_STEP = 9'd2;

    // Operations the controller asks of the datapath.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,   // capture request and start stack reads
        OP_EXEC,   // finish a command that needs no divider
        OP_DSTART, // start the divider
        OP_DDONE   // write the quotient back
    } t_op;

    typedef struct packed {
        t_op op;
    } t_ctrl;

    typedef struct packed {
        logic div_start;  // command is a legal division
        logic div_done;
    } t_stat;

endpackage

// File: rtl/sme_div.sv
// Iterative signed divider, one quotient bit per cycle.
module sme_div
    import sme_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [31:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_neg, r_done;
    logic [32:0] w_try;

    // One restoring step on the magnitude.
    always_comb begin
        w_try = {r_rem[31:0], r_q[31]} - {1'b0, r_den};
        if (!w_try[32]) begin
            n_rem = w_try;
            n_q   = {r_q[30:0], 1'b1};
        end else begin
            n_rem = {r_rem[31:0], r_q[31]};
            n_q   = {r_q[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_q    <= i_num[31] ? (32'd0 - i_num) : i_num;
                r_den  <= i_den[31] ? (32'd0 - i_den) : i_den;
                r_rem  <= 33'd0;
                r_neg  <= i_num[31] ^ i_den[31];
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (32'd0 - r_q) : r_q;
endmodule

// File: rtl/sme_dp.sv
// Datapath: registers, both stacks, ALU and the result register.
module sme_dp
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH  = 128,
    parameter int RETURN_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_ctrl,
    output t_stat       o_stat,
    input  logic [3:0]  i_command,
    input  logic [7:0]  i_operand,
    input  logic [7:0]  i_pc,
    input  logic [31:0] i_in_value,
    output logic        o_out_valid,
    output logic [31:0] o_out_value,
    output logic        o_branch_taken,
    output logic [8:0]  o_branch_target,
    output logic [1:0]  o_error_code
);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int DA = $clog2(STACK_DEPTH);
    localparam int RW = $clog2(RETURN_DEPTH + 1);
    localparam int RA = $clog2(RETURN_DEPTH);

    logic [31:0] r_dstk [STACK_DEPTH];
    logic [8:0]  r_rstk [RETURN_DEPTH];
    logic [31:0] r_gr   [4];
    logic [DW-1:0] r_dcnt;
    logic [RW-1:0] r_rcnt;
    logic [3:0]  r_cmd;
    logic [7:0]  r_opnd, r_pc;
    logic [31:0] r_inval, r_top, r_sec;
    logic [8:0]  r_rtop;
    logic [DA-1:0] w_a1, w_a2;
    logic [RA-1:0] w_ra;
    logic        w_isreg, w_und2, w_full;
    logic [1:0]  w_ri;
    logic [31:0] w_prod;
    logic        w_dstart;
    logic        w_ddone;
    logic [31:0] w_quot;

    // Read addresses of the top two data entries and the return top.
    assign w_a1 = DA'(r_dcnt - DW'(1));
    assign w_a2 = DA'(r_dcnt - DW'(2));
    assign w_ra = RA'(r_rcnt - RW'(1));
    assign w_isreg = (r_opnd >= REG_CODE_FIRST) && (r_opnd <= REG_CODE_LAST);
    assign w_ri    = 2'(r_opnd - REG_CODE_FIRST);
    assign w_und2  = r_dcnt < DW'(2);
    assign w_full  = r_dcnt >= DW'(STACK_DEPTH);
    assign w_prod  = r_top * r_sec;
    assign w_dstart = (i_ctrl.op == OP_DSTART);
    assign o_stat = '{div_start: (r_cmd == CMD_DIV) && !w_und2 && (r_sec != 32'd0),
                      div_done:  w_ddone};

    sme_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_dstart),
        .i_num  (r_top),
        .i_den  (r_sec),
        .o_done (w_ddone),
        .o_quot (w_quot)
    );

    // Capture the request and read the stack memories.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == OP_LOAD) begin
            r_cmd   <= i_command;
            r_opnd  <= i_operand;
            r_pc    <= i_pc;
            r_inval <= i_in_value;
        end
        r_top  <= r_dstk[w_a1];
        r_sec  <= r_dstk[w_a2];
        r_rtop <= r_rstk[w_ra];
    end

    // Stack memory writes.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == OP_EXEC) begin
            if (r_cmd == CMD_IN && !w_full)
                r_dstk[DA'(r_dcnt)] <= r_inval;
            if (r_cmd == CMD_PUT && !w_full)
                r_dstk[DA'(r_dcnt)] <= w_isreg ? r_gr[w_ri] : {24'd0, r_opnd};
            if ((r_cmd == CMD_ADD) && !w_und2) r_dstk[w_a2] <= r_top + r_sec;
            if ((r_cmd == CMD_MUL) && !w_und2) r_dstk[w_a2] <= w_prod;
            if (r_cmd == CMD_GOSUB && r_rcnt < RW'(RETURN_DEPTH))
                r_rstk[RA'(r_rcnt)] <= {1'b0, r_pc} + CALL_RETURN_STEP;
        end else if (i_ctrl.op == OP_DDONE) begin
            r_dstk[w_a2] <= w_quot;
        end
    end

    // Counts, registers and the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
            r_rcnt <= '0;
            for (int k = 0; k < 4; k++) r_gr[k] <= 32'd0;
            o_out_valid <= 1'b0; o_out_value <= 32'd0;
            o_branch_taken <= 1'b0; o_branch_target <= 9'd0;
            o_error_code <= ERR_OK;
        end else if (i_ctrl.op == OP_DDONE) begin
            r_dcnt <= r_dcnt - DW'(1);
            o_out_valid <= 1'b0; o_out_value <= 32'd0;
            o_branch_taken <= 1'b0; o_branch_target <= 9'd0;
            o_error_code <= ERR_OK;
        end else if (i_ctrl.op == OP_EXEC) begin
            o_out_valid <= 1'b0; o_out_value <= 32'd0;
            o_branch_taken <= 1'b0; o_branch_target <= 9'd0;
            o_error_code <= ERR_OK;
            unique case (r_cmd)
                CMD_CLEAR: begin
                    r_dcnt <= '0; r_rcnt <= '0;
                    for (int k = 0; k < 4; k++) r_gr[k] <= 32'd0;
                end
                CMD_IN, CMD_PUT: begin
                    if (w_full) o_error_code <= ERR_OVER;
                    else r_dcnt <= r_dcnt + DW'(1);
                end
                CMD_OUT: begin
                    if (r_dcnt == '0) o_error_code <= ERR_UNDER;
                    else begin
                        r_dcnt <= r_dcnt - DW'(1);
                        o_out_valid <= 1'b1;
                        o_out_value <= r_top;
                    end
                end
                CMD_POP: begin
                    if (w_isreg) begin
                        if (r_dcnt == '0) o_error_code <= ERR_UNDER;
                        else begin
                            r_dcnt <= r_dcnt - DW'(1);
                            r_gr[w_ri] <= r_top;
                        end
                    end
                end
                CMD_ADD, CMD_MUL: begin
                    if (w_und2) o_error_code <= ERR_UNDER;
                    else r_dcnt <= r_dcnt - DW'(1);
                end
                CMD_DIV: begin
                    if (w_und2) o_error_code <= ERR_UNDER;
                    else o_error_code <= ERR_DIV0;
                end
                CMD_JMP: begin
                    o_branch_taken <= 1'b1; o_branch_target <= {1'b0, r_opnd};
                end
                CMD_JE, CMD_JAE: begin
                    if (w_und2) o_error_code <= ERR_UNDER;
                    else if ((r_cmd == CMD_JE) ? (r_sec == r_top)
                             : ($signed(r_sec) >= $signed(r_top))) begin
                        o_branch_taken <= 1'b1; o_branch_target <= {1'b0, r_opnd};
                    end
                end
                CMD_GOSUB: begin
                    if (r_rcnt >= RW'(RETURN_DEPTH)) o_error_code <= ERR_OVER;
                    else begin
                        r_rcnt <= r_rcnt + RW'(1);
                        o_branch_taken <= 1'b1; o_branch_target <= {1'b0, r_opnd};
                    end
                end
                CMD_RET: begin
                    if (r_rcnt != '0) begin
                        r_rcnt <= r_rcnt - RW'(1);
                        o_branch_taken <= 1'b1; o_branch_target <= r_rtop;
                    end
                end
                CMD_END: r_dcnt <= '0;
                default: ;
            endcase
        end
    end
endmodule

// File: rtl/sme_ctrl.sv
// Controller state machine sequencing one request at a time.
module sme_ctrl
    import sme_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);
    typedef enum logic [2:0] {S_IDLE, S_READ, S_DIV, S_OUT} t_state;
    t_state r_state;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    // Command to the datapath in each state.
    always_comb begin
        o_ctrl.op = OP_NONE;
        unique case (r_state)
            S_IDLE: if (i_valid) o_ctrl.op = OP_LOAD;
            S_READ: o_ctrl.op = i_stat.div_start ? OP_DSTART : OP_EXEC;
            S_DIV:  if (i_stat.div_done) o_ctrl.op = OP_DDONE;
            S_OUT:  o_ctrl.op = OP_NONE;
            default: o_ctrl.op = OP_NONE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) r_state <= S_READ;
                S_READ: r_state <= i_stat.div_start ? S_DIV : S_OUT;
                S_DIV:  if (i_stat.div_done) r_state <= S_OUT;
                S_OUT:  if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/stack_machine_execute.sv
// Top level of the stack machine execute unit.
// Executes one instruction per request on a valid/ready input channel and
// returns one result per request on a valid/ready output channel.
// Each request is handled on its own: it is captured and the stack memories
// are read, then it is executed and the result registered, and the result
// is then shown until the receiver takes it.
// Division runs an iterative divider of one quotient bit per cycle. The
// stack memory read port sets the two-step flow.
// Reset clears the registers and both stack counts; it needs no clearing
// pass. When the receiver stalls the result holds and no new request is
// taken until it is delivered. Unused command codes give an all-zero
// result. Errors leave all state unchanged.
module stack_machine_execute
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH  = 128,
    parameter int RETURN_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_command,
    input  logic [7:0]  i_operand,
    input  logic [7:0]  i_pc,
    input  logic signed [31:0] i_in_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_out_valid,
    output logic signed [31:0] o_out_value,
    output logic        o_branch_taken,
    output logic [8:0]  o_branch_target,
    output logic [1:0]  o_error_code
);
    t_ctrl w_ctrl;
    t_stat w_stat;

    sme_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .i_stat(w_stat), .o_ctrl(w_ctrl)
    );

    sme_dp #(.STACK_DEPTH(STACK_DEPTH), .RETURN_DEPTH(RETURN_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(w_ctrl), .o_stat(w_stat),
        .i_command(i_command), .i_operand(i_operand), .i_pc(i_pc),
        .i_in_value(i_in_value), .o_out_valid(o_out_valid),
        .o_out_value(o_out_value), .o_branch_taken(o_branch_taken),
        .o_branch_target(o_branch_target), .o_error_code(o_error_code)
    );
endmodule

// File: rtl/sme_checker.sv
// Port-level checks for the stack machine execute unit, bound to the top.
module sme_checker
    import sme_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_out_valid,
    input logic       o_branch_taken,
    input logic [8:0] o_branch_target,
    input logic [1:0] o_error_code
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("request taken while result pending");
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("second request taken at once");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code != ERR_OK |-> !o_out_valid && !o_branch_taken)
        else $error("error result with effect");
    a_tgt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_branch_taken |-> o_branch_target == 9'd0)
        else $error("stray branch target");
endmodule

bind stack_machine_execute sme_checker u_sme_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_out_valid(o_out_valid),
    .o_branch_taken(o_branch_taken), .o_branch_target(o_branch_target),
    .o_error_code(o_error_code)
);

// File: test/tb_stack_machine_execute.sv
// Self-checking testbench for the stack machine execute unit.
`timescale 1ns / 100ps

module tb_stack_machine_execute;
    import sme_pkg::*;

    localparam int STACK_DEPTH  = 128;
    localparam int RETURN_DEPTH = 16;
    localparam int RANDOM_ITEMS = 980;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic        out_valid;
        logic [31:0] out_value;
        logic        branch_taken;
        logic [8:0]  branch_target;
        logic [1:0]  error_code;
    } t_result;

    typedef struct {
        logic [3:0]  command;
        logic [7:0]  operand;
        logic [7:0]  pc;
        logic [31:0] in_value;
        logic        typed;    // expected result is written in the row
        t_result     result;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [3:0]  i_command = '0;
    logic [7:0]  i_operand = '0;
    logic [7:0]  i_pc = '0;
    logic signed [31:0] i_in_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_out_valid;
    logic signed [31:0] o_out_value;
    logic        o_branch_taken;
    logic [8:0]  o_branch_target;
    logic [1:0]  o_error_code;

    // Machine state mirrored by the predictor.
    logic [31:0] gp_regs [4];
    logic [31:0] data_mem [STACK_DEPTH];
    int          data_depth;
    logic [8:0]  ret_mem [RETURN_DEPTH];
    int          ret_depth;

    t_result     pending_results [$];
    int          mismatches = 0;
    int          cycles = 0;
    t_row        rows [$];

    stack_machine_execute #(
        .STACK_DEPTH (STACK_DEPTH),
        .RETURN_DEPTH(RETURN_DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_operand      (i_operand),
        .i_pc           (i_pc),
        .i_in_value     (i_in_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_valid    (o_out_valid),
        .o_out_value    (o_out_value),
        .o_branch_taken (o_branch_taken),
        .o_branch_target(o_branch_target),
        .o_error_code   (o_error_code)
    );

    always #2 i_clk = ~i_clk;

    // Random gap length: mostly short, now and then long.
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic int reg_slot(logic [7:0] code);
        if (code >= REG_CODE_FIRST && code <= REG_CODE_LAST) return code - REG_CODE_FIRST;
        return -1;
    endfunction

    function automatic logic [31:0] quotient(logic [31:0] num, logic [31:0] den);
        longint q;
        q = longint'($signed(num)) / longint'($signed(den));
        return q[31:0];
    endfunction

    // Executes one instruction on the mirrored state and returns its result.
    function automatic t_result execute_instr(logic [3:0] cmd, logic [7:0] opnd,
                                              logic [7:0] pc, logic [31:0] inval);
        t_result     r;
        logic [31:0] top;
        logic [31:0] second;
        int          slot;
        r = '0;
        case (cmd)
            CMD_CLEAR: begin
                for (int k = 0; k < 4; k++) gp_regs[k] = '0;
                data_depth = 0;
                ret_depth = 0;
            end
            CMD_IN, CMD_PUT: begin
                if (data_depth >= STACK_DEPTH) begin
                    r.error_code = ERR_OVER;
                end else begin
                    slot = reg_slot(opnd);
                    if (cmd == CMD_IN) data_mem[data_depth] = inval;
                    else data_mem[data_depth] = (slot >= 0) ? gp_regs[slot] : {24'd0, opnd};
                    data_depth++;
                end
            end
            CMD_OUT: begin
                if (data_depth == 0) begin
                    r.error_code = ERR_UNDER;
                end else begin
                    data_depth--;
                    r.out_value = data_mem[data_depth];
                    r.out_valid = 1'b1;
                end
            end
            CMD_POP: begin
                slot = reg_slot(opnd);
                if (slot >= 0) begin
                    if (data_depth == 0) begin
                        r.error_code = ERR_UNDER;
                    end else begin
                        data_depth--;
                        gp_regs[slot] = data_mem[data_depth];
                    end
                end
            end
            CMD_ADD, CMD_MUL, CMD_DIV, CMD_JE, CMD_JAE: begin
                if (data_depth < 2) begin
                    r.error_code = ERR_UNDER;
                end else begin
                    top = data_mem[data_depth - 1];
                    second = data_mem[data_depth - 2];
                    if (cmd == CMD_JE || cmd == CMD_JAE) begin
                        if (cmd == CMD_JE ? (second == top)
                                          : ($signed(second) >= $signed(top))) begin
                            r.branch_taken = 1'b1;
                            r.branch_target = {1'b0, opnd};
                        end
                    end else if (cmd == CMD_DIV && second == 0) begin
                        r.error_code = ERR_DIV0;
                    end else begin
                        data_depth--;
                        if (cmd == CMD_ADD) data_mem[data_depth - 1] = top + second;
                        else if (cmd == CMD_MUL) data_mem[data_depth - 1] = top * second;
                        else data_mem[data_depth - 1] = quotient(top, second);
                    end
                end
            end
            CMD_JMP: begin
                r.branch_taken = 1'b1;
                r.branch_target = {1'b0, opnd};
            end
            CMD_GOSUB: begin
                if (ret_depth >= RETURN_DEPTH) begin
                    r.error_code = ERR_OVER;
                end else begin
                    ret_mem[ret_depth] = {1'b0, pc} + CALL_RETURN_STEP;
                    ret_depth++;
                    r.branch_taken = 1'b1;
                    r.branch_target = {1'b0, opnd};
                end
            end
            CMD_RET: begin
                if (ret_depth > 0) begin
                    ret_depth--;
                    r.branch_target = ret_mem[ret_depth];
                    r.branch_taken = 1'b1;
                end
            end
            CMD_END: data_depth = 0;
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("MISMATCH %s: got %0h expected %0h (cycle %0d)", what, got, want, cycles);
    endtask

    task automatic add_row(logic [3:0] cmd, logic [7:0] opnd, logic [7:0] pc,
                           logic [31:0] inval, logic typed = 1'b0, t_result res = '0);
        t_row row;
        row.command = cmd;
        row.operand = opnd;
        row.pc = pc;
        row.in_value = inval;
        row.typed = typed;
        row.result = res;
        rows.push_back(row);
    endtask

    // Sends one request; the predictor runs at the accepting edge.
    // Valid stays high into the next request when there is no gap.
    task automatic send_request(t_row row);
        t_result predicted;
        int      gap;
        gap = gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command <= row.command;
        i_operand <= row.operand;
        i_pc <= row.pc;
        i_in_value <= row.in_value;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        predicted = execute_instr(row.command, row.operand, row.pc, row.in_value);
        if (row.typed && predicted != row.result)
            report_mismatch("directed row", 64'(predicted), 64'(row.result));
        pending_results.push_back(predicted);
    endtask

    // Random stack-heavy instruction with random content.
    task automatic random_row();
        logic [3:0]  cmd;
        logic [7:0]  opnd;
        logic [31:0] val;
        int          roll;
        roll = $urandom_range(99);
        if (roll < 18) cmd = CMD_IN;
        else if (roll < 30) cmd = CMD_PUT;
        else if (roll < 97) cmd = 4'($urandom_range(13, 2));
        else if (roll < 98) cmd = CMD_CLEAR;
        else cmd = 4'($urandom_range(15, 14));
        case ($urandom_range(3))
            0: opnd = 8'($urandom_range(REG_CODE_LAST, REG_CODE_FIRST));
            default: opnd = 8'($urandom);
        endcase
        case ($urandom_range(5))
            0: val = 32'h8000_0000;
            1: val = 32'hFFFF_FFFF;
            2: val = 32'($urandom_range(3));
            default: val = $urandom;
        endcase
        add_row(cmd, opnd, 8'($urandom), val);
    endtask

    // Output side: random stalls and field-by-field checks.
    always @(posedge i_clk) begin
        t_result want;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 64'd0, 64'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_valid !== want.out_valid)
                        report_mismatch("out_valid", 64'(o_out_valid), 64'(want.out_valid));
                    if (o_out_value !== want.out_value)
                        report_mismatch("out_value", 64'(unsigned'(o_out_value)),
                                        64'(want.out_value));
                    if (o_branch_taken !== want.branch_taken)
                        report_mismatch("branch_taken", 64'(o_branch_taken),
                                        64'(want.branch_taken));
                    if (o_branch_target !== want.branch_target)
                        report_mismatch("branch_target", 64'(o_branch_target),
                                        64'(want.branch_target));
                    if (o_error_code !== want.error_code)
                        report_mismatch("error_code", 64'(o_error_code), 64'(want.error_code));
                end
            end
            if ($urandom_range(99) < 30) i_ready <= ~i_ready;
            else if ($urandom_range(99) < 3) i_ready <= 1'b0;
            else if (!i_ready && $urandom_range(99) < 40) i_ready <= 1'b1;
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_result res;
        for (int k = 0; k < 4; k++) gp_regs[k] = '0;
        data_depth = 0;
        ret_depth = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: empty-stack errors, extremes, division cases.
        res = '0; res.error_code = ERR_UNDER;
        add_row(CMD_OUT, 8'd0, 8'd0, 32'd0, 1'b1, res);
        add_row(CMD_ADD, 8'd0, 8'd0, 32'd0, 1'b1, res);
        add_row(CMD_POP, REG_CODE_FIRST, 8'd0, 32'd0, 1'b1, res);
        res = '0;
        add_row(CMD_POP, 8'd7, 8'd0, 32'd0, 1'b1, res);
        add_row(CMD_RET, 8'd0, 8'd0, 32'd0, 1'b1, res);
        add_row(4'd14, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, res);
        add_row(4'd15, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, res);
        res = '0; res.branch_taken = 1'b1; res.branch_target = 9'd255;
        add_row(CMD_JMP, 8'hFF, 8'd0, 32'd0, 1'b1, res);
        res.branch_target = 9'd257;
        add_row(CMD_GOSUB, 8'hFF, 8'hFF, 32'd0);
        add_row(CMD_RET, 8'd0, 8'd0, 32'd0, 1'b1, res);
        add_row(CMD_PUT, REG_CODE_LAST, 8'd0, 32'd0);
        add_row(CMD_IN, 8'd0, 8'd0, 32'h7FFF_FFFF);
        add_row(CMD_DIV, 8'd0, 8'd0, 32'd0);
        res = '0; res.error_code = ERR_DIV0;
        add_row(CMD_DIV, 8'd0, 8'd0, 32'd0, 1'b1, res);
        add_row(CMD_END, 8'd0, 8'd0, 32'd0);
        add_row(CMD_IN, 8'd0, 8'd0, 32'hFFFF_FFFF);
        add_row(CMD_IN, 8'd0, 8'd0, 32'h8000_0000);
        add_row(CMD_JAE, 8'd9, 8'd0, 32'd0);
        add_row(CMD_JE, 8'd9, 8'd0, 32'd0);
        add_row(CMD_DIV, 8'd0, 8'd0, 32'd0);
        add_row(CMD_PUT, 8'hFF, 8'd0, 32'd0);
        add_row(CMD_MUL, 8'd0, 8'd0, 32'd0);
        add_row(CMD_POP, REG_CODE_LAST, 8'd0, 32'd0);
        add_row(CMD_CLEAR, 8'd0, 8'd0, 32'd0);
        foreach (rows[k]) send_request(rows[k]);
        rows.delete();

        // Fill both stacks to overflow.
        for (int k = 0; k <= STACK_DEPTH; k++) add_row(CMD_IN, 8'd0, 8'd0, $urandom);
        for (int k = 0; k <= RETURN_DEPTH; k++)
            add_row(CMD_GOSUB, 8'($urandom), 8'($urandom), 32'd0);
        add_row(CMD_END, 8'd0, 8'd0, 32'd0);
        foreach (rows[k]) send_request(rows[k]);
        rows.delete();
        i_valid <= 1'b0;

        // Let every result drain before the random phase.
        wait (pending_results.size() == 0);

        for (int k = 0; k < RANDOM_ITEMS; k++) random_row();
        foreach (rows[k]) send_request(rows[k]);
        i_valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/sme_pkg.sv
rtl/sme_div.sv
rtl/sme_dp.sv
rtl/sme_ctrl.sv
rtl/stack_machine_execute.sv
rtl/sme_checker.sv
test/tb_stack_machine_execute.sv
